// ===== design/tegb_pkg.sv =====
`timescale 1ns / 1ps
package tegb_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MSB_W      = 5;
	localparam int LOG_W      = MSB_W + FRAC_BITS;
	localparam int NUM_BANDS  = 5;
	localparam int HALF_LOG2E = 47274;
	localparam int WSUM_FLOOR = 7;
	localparam int MG_MIN     = 655;
	localparam int MG_MAX     = 65536;
	localparam int BW_MIN     = 128;
	localparam int BW_MAX     = 2048;
	localparam int GAIN_LIM   = 1280;
	localparam int EXP_BIAS   = 16;

	typedef enum logic [2:0] {
		REG_MIDDLE_GREY     = 3'd0,
		REG_BAND_WIDTH      = 3'd1,
		REG_GAIN_SHADOWS    = 3'd2,
		REG_GAIN_DARKS      = 3'd3,
		REG_GAIN_MIDTONES   = 3'd4,
		REG_GAIN_LIGHTS     = 3'd5,
		REG_GAIN_HIGHLIGHTS = 3'd6
	} reg_idx_t;

	function automatic logic [63:0] floor_sqrt64(logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] res;
		logic [63:0] bt;
		a   = a_in;
		res = '0;
		bt  = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (a >= res + bt) begin
				a   = a - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q0.32
	function automatic logic [31:0] pow_rom_f(int k);
		logic [63:0] p;
		p = floor_sqrt64(64'h8000_0000_0000_0000);
		for (int j = 2; j <= FRAC_BITS; j++) begin
			if (j <= k) begin
				p = floor_sqrt64(p << 32);
			end
		end
		return p[31:0];
	endfunction

endpackage

// ===== design/tegb_in_if.sv =====
`timescale 1ns / 1ps
interface tegb_in_if #(
	parameter int VALUE_WIDTH = 24
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] scene_in;

	modport source(output valid, output scene_in, input ready);
	modport sink(input valid, input scene_in, output ready);
endinterface

// ===== design/tegb_out_if.sv =====
`timescale 1ns / 1ps
interface tegb_out_if #(
	parameter int VALUE_WIDTH = 24
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] scene_out;
	logic                   saturated;

	modport source(output valid, output scene_out, output saturated, input ready);
	modport sink(input valid, input scene_out, input saturated, output ready);
endinterface

// ===== design/tegb_log2.sv =====
`timescale 1ns / 1ps
module tegb_log2 import tegb_pkg::*; #(
	parameter int IN_W   = 24,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [IN_W-1:0]   v_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [LOG_W-1:0]  res_o,
	output logic [SIDE_W-1:0] side_o
);
	localparam int STAGES = FRAC_BITS;

	logic [MSB_W-1:0]     msb_n;
	logic [62:0]          norm_n;
	logic                 vld_s  [0:STAGES];
	logic [30:0]          m_s    [0:STAGES];
	logic [MSB_W-1:0]     msb_s  [0:STAGES];
	logic [FRAC_BITS-1:0] frac_s [0:STAGES];
	logic [SIDE_W-1:0]    side_s [0:STAGES];

	always_comb begin
		msb_n = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (v_i[i]) begin
				msb_n = MSB_W'(i);
			end
		end
		norm_n = (63'(v_i) << 30) >> msb_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
			for (int k = 1; k <= STAGES; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= norm_n[30:0];
			msb_s[0]  <= msb_n;
			frac_s[0] <= '0;
			side_s[0] <= side_i;
		end
	end

	// one squaring of the Q1.30 mantissa per stage, one fraction bit out
	for (genvar k = 1; k <= STAGES; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] m2;
		assign sq = 62'(m_s[k-1]) * 62'(m_s[k-1]);
		assign m2 = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k]    <= m2[31] ? m2[31:1] : m2[30:0];
				frac_s[k] <= {frac_s[k-1][FRAC_BITS-2:0], m2[31]};
				msb_s[k]  <= msb_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[STAGES];
	assign res_o  = {msb_s[STAGES], frac_s[STAGES]};
	assign side_o = side_s[STAGES];
endmodule

// ===== design/tegb_div.sv =====
`timescale 1ns / 1ps
module tegb_div import tegb_pkg::*; #(
	parameter int NUM_W  = 29,
	parameter int DEN_W  = 12,
	parameter int Q_W    = 22,
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic signed [NUM_W:0]   num_i,
	input  logic [DEN_W-1:0]        den_i,
	input  logic [SIDE_W-1:0]       side_i,
	output logic                    vld_o,
	output logic signed [Q_W:0]     q_o,
	output logic [SIDE_W-1:0]       side_o
);
	localparam int REM_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

	logic [NUM_W:0]     mag_n;
	logic [Q_W:0]       qe;
	logic               vld_s  [0:Q_W];
	logic [REM_W-1:0]   rem_s  [0:Q_W];
	logic [DEN_W-1:0]   den_s  [0:Q_W];
	logic [Q_W-1:0]     q_s    [0:Q_W];
	logic               neg_s  [0:Q_W];
	logic [SIDE_W-1:0]  side_s [0:Q_W];

	assign mag_n = num_i[NUM_W] ? (NUM_W+1)'(-num_i) : (NUM_W+1)'(num_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
			for (int k = 1; k <= Q_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= REM_W'(mag_n[NUM_W-1:0]);
			den_s[0]  <= den_i;
			q_s[0]    <= '0;
			neg_s[0]  <= num_i[NUM_W];
			side_s[0] <= side_i;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [REM_W-1:0] dsh;
		logic             take;
		assign dsh  = REM_W'(den_s[k-1]) << (Q_W - k);
		assign take = rem_s[k-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_s[k-1] - dsh : rem_s[k-1];
				q_s[k]    <= {q_s[k-1][Q_W-2:0], take};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign qe     = {1'b0, q_s[Q_W]};
	assign q_o    = neg_s[Q_W] ? $signed(-qe) : $signed(qe);
	assign vld_o  = vld_s[Q_W];
	assign side_o = side_s[Q_W];
endmodule

// ===== design/tegb_pow2.sv =====
`timescale 1ns / 1ps
module tegb_pow2 import tegb_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  logic [FRAC_BITS-1:0] r_i,
	input  logic [SIDE_W-1:0]    side_i,
	output logic                 vld_o,
	output logic [32:0]          p_o,
	output logic [SIDE_W-1:0]    side_o
);
	localparam int STAGES = FRAC_BITS;

	logic                 vld_s  [0:STAGES];
	logic [32:0]          p_s    [0:STAGES];
	logic [FRAC_BITS-1:0] r_s    [0:STAGES];
	logic [SIDE_W-1:0]    side_s [0:STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
			for (int k = 1; k <= STAGES; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0]    <= 33'h1_0000_0000;
			r_s[0]    <= r_i;
			side_s[0] <= side_i;
		end
	end

	// Q1.32 product of 2^(-2^-k) factors, MSB of r first
	for (genvar k = 1; k <= STAGES; k++) begin : g_mul
		localparam logic [31:0] FK = pow_rom_f(k);
		logic [64:0] prod;
		assign prod = 65'(p_s[k-1]) * 65'(FK);
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k]    <= r_s[k-1][FRAC_BITS-k] ? prod[64:32] : p_s[k-1];
				r_s[k]    <= r_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[STAGES];
	assign p_o    = p_s[STAGES];
	assign side_o = side_s[STAGES];
endmodule

// ===== design/tone_equalizer_band_gain_core.sv =====
`timescale 1ns / 1ps
// Five-band tone equalizer gain stage.
// pix_in carries one scene-linear luminance beat (scene_in, unsigned Q8.16);
// pix_out returns the adjusted luminance (scene_out) and a saturated flag,
// one result beat for every input beat, in order. Both use valid/ready.
// The APB port holds middle grey, band width and the five band gains at
// byte addresses 0x00..0x18; write them only while no beat is in flight.
// From input accept to output valid a beat passes the log2 squaring chain,
// the stops divider, band distance math, the band weight exp2 chain,
// weighting and sums, the gain divider, exponent prep, the final exp2 chain
// and the multiply, add and shift/saturate registers. Throughput is one beat
// per cycle while pix_out does not stall.
// Reset clears all valid bits and loads the register defaults.
// When pix_out stalls, the whole pipeline holds and pix_in.ready drops in the
// same cycle; nothing is dropped or repeated.
module tone_equalizer_band_gain_core import tegb_pkg::*; #(
	parameter int VALUE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	tegb_in_if.sink     pix_in,
	tegb_out_if.source  pix_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int VW     = VALUE_WIDTH;
	localparam int EV_W   = LOG_W + 1;
	localparam int NUM1_W = EV_W + 7;
	localparam int Q1_W   = NUM1_W - 7;
	localparam int T_W    = Q1_W + 1;
	localparam int D_W    = T_W + 1;
	localparam int SQ_W   = 2 * D_W;
	localparam int E_W    = SQ_W;
	localparam int W_W    = 17;
	localparam int PR_W   = 12 + W_W + 1;
	localparam int SUM_W  = PR_W + 3;
	localparam int WS_W   = W_W + 3;
	localparam int NUM2_W = SUM_W + 7;
	localparam int Q2_W   = 20;
	localparam int G_W    = Q2_W + 1;
	localparam int U_W    = 21;
	localparam int UI_W   = U_W - FRAC_BITS;
	localparam int Y_W    = VW + 33;
	localparam int IP_W   = E_W - 32;

	// configuration
	logic [16:0]        mg_q;
	logic [11:0]        bw_q;
	logic signed [11:0] gain_q [0:NUM_BANDS-1];
	logic [16:0]        mg_c;
	logic [11:0]        bw_c;
	logic signed [11:0] gain_c [0:NUM_BANDS-1];
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mg_q <= 17'(11796);
			bw_q <= 12'(512);
			for (int i = 0; i < NUM_BANDS; i++) gain_q[i] <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_MIDDLE_GREY:     mg_q      <= pwdata[16:0];
				REG_BAND_WIDTH:      bw_q      <= pwdata[11:0];
				REG_GAIN_SHADOWS:    gain_q[0] <= pwdata[11:0];
				REG_GAIN_DARKS:      gain_q[1] <= pwdata[11:0];
				REG_GAIN_MIDTONES:   gain_q[2] <= pwdata[11:0];
				REG_GAIN_LIGHTS:     gain_q[3] <= pwdata[11:0];
				REG_GAIN_HIGHLIGHTS: gain_q[4] <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_MIDDLE_GREY:     prdata = 32'(mg_q);
			REG_BAND_WIDTH:      prdata = 32'(bw_q);
			REG_GAIN_SHADOWS:    prdata = 32'(gain_q[0]);
			REG_GAIN_DARKS:      prdata = 32'(gain_q[1]);
			REG_GAIN_MIDTONES:   prdata = 32'(gain_q[2]);
			REG_GAIN_LIGHTS:     prdata = 32'(gain_q[3]);
			REG_GAIN_HIGHLIGHTS: prdata = 32'(gain_q[4]);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		mg_c = (mg_q < 17'(MG_MIN)) ? 17'(MG_MIN) : ((mg_q > 17'(MG_MAX)) ? 17'(MG_MAX) : mg_q);
		bw_c = (bw_q < 12'(BW_MIN)) ? 12'(BW_MIN) : ((bw_q > 12'(BW_MAX)) ? 12'(BW_MAX) : bw_q);
		for (int i = 0; i < NUM_BANDS; i++) begin
			if (gain_q[i] < -12'sd1280) gain_c[i] = -12'sd1280;
			else if (gain_q[i] > 12'sd1280) gain_c[i] = 12'sd1280;
			else gain_c[i] = gain_q[i];
		end
	end

	// pipeline advance
	logic          en;
	logic          out_valid_q;
	logic [VW-1:0] scene_out_q;
	logic          sat_q;

	assign en           = !out_valid_q || pix_out.ready;
	assign pix_in.ready = en;

	// log2 of input and of middle grey
	logic [VW-1:0]    x_f;
	logic             lx_vld;
	logic [LOG_W-1:0] lx;
	logic [LOG_W-1:0] lm;
	logic [VW-1:0]    lx_x;

	assign x_f = (pix_in.scene_in == '0) ? VW'(1) : pix_in.scene_in;

	tegb_log2 #(.IN_W(VW), .SIDE_W(VW)) u_log_x (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(pix_in.valid),
		.v_i(x_f), .side_i(x_f),
		.vld_o(lx_vld), .res_o(lx), .side_o(lx_x)
	);

	tegb_log2 #(.IN_W(17), .SIDE_W(1)) u_log_mg (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(pix_in.valid),
		.v_i(mg_c), .side_i(1'b0),
		.vld_o(), .res_o(lm), .side_o()
	);

	// stops in band widths
	logic signed [EV_W-1:0] ev;
	logic signed [NUM1_W:0] t_num;
	logic                   t_vld;
	logic signed [Q1_W:0]   t_q;
	logic [VW-1:0]          t_x;

	assign ev    = $signed({1'b0, lx}) - $signed({1'b0, lm});
	assign t_num = {ev, 8'b0};

	tegb_div #(.NUM_W(NUM1_W), .DEN_W(12), .Q_W(Q1_W), .SIDE_W(VW)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(lx_vld),
		.num_i(t_num), .den_i(bw_c), .side_i(lx_x),
		.vld_o(t_vld), .q_o(t_q), .side_o(t_x)
	);

	// band lanes
	logic                  vld_s1, vld_s2, vld_s3;
	logic [VW-1:0]         x_s1, x_s2, x_s3;
	logic [D_W-1:0]        d_s1  [0:NUM_BANDS-1];
	logic [SQ_W-1:0]       sq_s2 [0:NUM_BANDS-1];
	logic [E_W-1:0]        e_s3  [0:NUM_BANDS-1];
	logic                  bp_vld  [0:NUM_BANDS-1];
	logic [32:0]           bp_p    [0:NUM_BANDS-1];
	logic [IP_W+VW-1:0]    bp_side [0:NUM_BANDS-1];
	logic                  vld_s4, vld_s5, vld_s6;
	logic [VW-1:0]         x_s4, x_s5, x_s6;
	logic [W_W-1:0]        w_s4  [0:NUM_BANDS-1];
	logic [W_W-1:0]        w_s5  [0:NUM_BANDS-1];
	logic signed [PR_W-1:0] pr_s5 [0:NUM_BANDS-1];
	logic signed [SUM_W-1:0] num_s6;
	logic [WS_W-1:0]       ws_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= t_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= bp_vld[0];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= t_x;
			x_s2 <= x_s1;
			x_s3 <= x_s2;
			x_s4 <= bp_side[0][VW-1:0];
			x_s5 <= x_s4;
			x_s6 <= x_s5;
		end
	end

	for (genvar i = 0; i < NUM_BANDS; i++) begin : g_band
		localparam int OFF = (i - NUM_BANDS / 2) * 65536;
		logic [IP_W-1:0] ip;
		logic [6:0]      sh;
		assign ip = bp_side[i][IP_W+VW-1:VW];
		assign sh = 7'(ip[5:0]) + 7'(FRAC_BITS);

		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[i]  <= D_W'({t_q[Q1_W], t_q}) - D_W'(OFF);
				sq_s2[i] <= SQ_W'($signed(d_s1[i]) * $signed(d_s1[i]));
				e_s3[i]  <= E_W'(sq_s2[i][SQ_W-1:FRAC_BITS]) * E_W'(HALF_LOG2E);
				w_s4[i]  <= (ip < IP_W'(48)) ? W_W'(bp_p[i] >> sh) : '0;
				w_s5[i]  <= w_s4[i];
				pr_s5[i] <= PR_W'($signed(gain_c[i]) * $signed({1'b0, w_s4[i]}));
			end
		end

		tegb_pow2 #(.SIDE_W(IP_W + VW)) u_pow (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s3),
			.r_i(e_s3[i][31:16]), .side_i({e_s3[i][E_W-1:32], x_s3}),
			.vld_o(bp_vld[i]), .p_o(bp_p[i]), .side_o(bp_side[i])
		);
	end

	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] acc;
		logic [WS_W-1:0]         ws;
		if (en) begin
			acc = '0;
			ws  = '0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				acc = acc + SUM_W'(pr_s5[i]);
				ws  = ws + WS_W'(w_s5[i]);
			end
			num_s6 <= acc;
			ws_s6  <= (ws < WS_W'(WSUM_FLOOR)) ? WS_W'(WSUM_FLOOR) : ws;
		end
	end

	// blended gain
	logic signed [NUM2_W:0] g_num;
	logic                   g_vld;
	logic signed [Q2_W:0]   g_q;
	logic [VW-1:0]          g_x;

	assign g_num = {num_s6, 8'b0};

	tegb_div #(.NUM_W(NUM2_W), .DEN_W(WS_W), .Q_W(Q2_W), .SIDE_W(VW)) u_div_g (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s6),
		.num_i(g_num), .den_i(ws_s6), .side_i(x_s6),
		.vld_o(g_vld), .q_o(g_q), .side_o(g_x)
	);

	// 2^gain and scale
	logic                vld_s7, vld_s8, vld_s9;
	logic [U_W-1:0]      u_s7;
	logic [VW-1:0]       x_s7, x_s8;
	logic [U_W:0]        u_n;
	logic                fp_vld;
	logic [32:0]         fp_p;
	logic [UI_W+VW-1:0]  fp_side;
	logic [VW+31:0]      ylo_s8;
	logic                hi_s8;
	logic [UI_W-1:0]     ui_s8, ui_s9;
	logic [Y_W-1:0]      y_s9;
	logic [5:0]          sh_o;
	logic [Y_W-1:0]      res_o;

	assign u_n = (U_W+1)'(EXP_BIAS * 65536) - (U_W+1)'($signed({g_q[Q2_W], g_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s7      <= g_vld;
			vld_s8      <= fp_vld;
			vld_s9      <= vld_s8;
			out_valid_q <= vld_s9;
		end
	end

	tegb_pow2 #(.SIDE_W(UI_W + VW)) u_pow_out (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s7),
		.r_i(u_s7[FRAC_BITS-1:0]), .side_i({u_s7[U_W-1:FRAC_BITS], x_s7}),
		.vld_o(fp_vld), .p_o(fp_p), .side_o(fp_side)
	);

	assign sh_o  = 6'(ui_s9) + 6'(FRAC_BITS);
	assign res_o = y_s9 >> sh_o;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s7   <= u_n[U_W-1:0];
			x_s7   <= g_x;
			x_s8   <= fp_side[VW-1:0];
			ylo_s8 <= (VW+32)'(fp_side[VW-1:0]) * (VW+32)'(fp_p[31:0]);
			hi_s8  <= fp_p[32];
			ui_s8  <= fp_side[UI_W+VW-1:VW];
			y_s9   <= Y_W'(ylo_s8) + (hi_s8 ? (Y_W'(x_s8) << 32) : '0);
			ui_s9  <= ui_s8;
			sat_q  <= |res_o[Y_W-1:VW];
			scene_out_q <= (|res_o[Y_W-1:VW]) ? '1 : res_o[VW-1:0];
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.scene_out = scene_out_q;
	assign pix_out.saturated = sat_q;
endmodule

// ===== test/tb_tone_equalizer_band_gain_core.sv =====
`timescale 1ns / 1ps
module tb_tone_equalizer_band_gain_core;
	import tegb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tegb_in_if  #(.VALUE_WIDTH(24)) pix_in();
	tegb_out_if #(.VALUE_WIDTH(24)) pix_out();

	tone_equalizer_band_gain_core #(.VALUE_WIDTH(24)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in),
		.pix_out(pix_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	typedef struct packed {
		logic [23:0] lum;
		logic        clip;
	} lum_result_t;

	lum_result_t        pending_lum[$];
	int                 err_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit [63:0]          exp2_rom[1:16];
	bit [16:0]          grey_reg;
	bit [11:0]          width_reg;
	bit [11:0]          band_gain_reg[5];

	always #5 clk = ~clk;

	function automatic bit [63:0] isqrt64(bit [63:0] a_in);
		bit [63:0] a;
		bit [63:0] root;
		bit [63:0] bt;
		a    = a_in;
		root = 0;
		bt   = 64'h1 << 62;
		while (bt > a) bt = bt >> 2;
		while (bt != 0) begin
			if (a >= root + bt) begin
				a    = a - (root + bt);
				root = (root >> 1) + bt;
			end else begin
				root = root >> 1;
			end
			bt = bt >> 2;
		end
		return root;
	endfunction

	function automatic bit [63:0] exp2_neg_frac(bit [15:0] r);
		bit [63:0] p;
		p = 64'h1 << 32;
		for (int k = 1; k <= 16; k++)
			if (r[16-k]) p = (p * exp2_rom[k]) >> 32;
		return p;
	endfunction

	function automatic longint log2_fix(bit [63:0] v);
		int        msb;
		bit [63:0] m;
		longint    acc;
		msb = 0;
		while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
		m   = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
		acc = longint'(msb) * 65536;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'h1 << 31)) begin
				m   = m >> 1;
				acc = acc + (longint'(1) << i);
			end
		end
		return acc;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic lum_result_t equalize(bit [23:0] lum_in);
		lum_result_t rs;
		bit [63:0]   x;
		bit [63:0]   e;
		bit [63:0]   ip;
		bit [63:0]   yy;
		bit [63:0]   sh;
		longint      ev, t, d, w, num, wsum, gain, u, g;
		int          n;
		x    = (lum_in == 0) ? 64'd1 : 64'(lum_in);
		ev   = log2_fix(x) - log2_fix(64'(clampl(grey_reg, MG_MIN, MG_MAX)));
		t    = (ev * 256) / clampl(width_reg, BW_MIN, BW_MAX);
		num  = 0;
		wsum = 0;
		for (int i = 0; i < NUM_BANDS; i++) begin
			d  = t - longint'(i - 2) * 65536;
			e  = ((64'(d * d)) >> 16) * HALF_LOG2E >> 16;
			ip = e >> 16;
			w  = 0;
			if (ip < 48) w = longint'(exp2_neg_frac(e[15:0]) >> (16 + ip));
			g    = longint'($signed(band_gain_reg[i]));
			wsum = wsum + w;
			num  = num + clampl(g, -GAIN_LIM, GAIN_LIM) * w;
		end
		if (wsum < WSUM_FLOOR) wsum = WSUM_FLOOR;
		gain = (num * 256) / wsum;
		u    = -gain + 16 * 65536;
		n    = int'(u >>> 16) - 16;
		yy   = x * exp2_neg_frac(u[15:0]);
		sh   = yy >> (32 + n);
		rs.clip = sh > 64'hFF_FFFF;
		rs.lum  = rs.clip ? 24'hFF_FFFF : sh[23:0];
		return rs;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		pix_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_lum.size() == 0) begin
				report_mismatch("unexpected beat", pix_out.scene_out, 0);
			end else begin
				if (pix_out.scene_out !== pending_lum[0].lum)
					report_mismatch("scene_out", pix_out.scene_out, pending_lum[0].lum);
				if (pix_out.saturated !== pending_lum[0].clip)
					report_mismatch("saturated", pix_out.saturated, pending_lum[0].clip);
				void'(pending_lum.pop_front());
			end
		end
	end

	task automatic apb_write(reg_idx_t r, bit [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(r) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (r)
			REG_MIDDLE_GREY: begin
				grey_reg = v[16:0];
			end
			REG_BAND_WIDTH: begin
				width_reg = v[11:0];
			end
			default: begin
				band_gain_reg[int'(r) - int'(REG_GAIN_SHADOWS)] = v[11:0];
			end
		endcase
	endtask

	task automatic send_lum(bit [23:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.scene_in <= v;
		do @(posedge clk); while (!pix_in.ready);
		pending_lum.push_back(equalize(v));
	endtask

	task automatic drain;
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_lum.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_all(bit [16:0] mg, bit [11:0] bw, bit [11:0] g0, bit [11:0] g1,
			bit [11:0] g2, bit [11:0] g3, bit [11:0] g4);
		apb_write(REG_MIDDLE_GREY, 32'(mg));
		apb_write(REG_BAND_WIDTH, 32'(bw));
		apb_write(REG_GAIN_SHADOWS, 32'(g0));
		apb_write(REG_GAIN_DARKS, 32'(g1));
		apb_write(REG_GAIN_MIDTONES, 32'(g2));
		apb_write(REG_GAIN_LIGHTS, 32'(g3));
		apb_write(REG_GAIN_HIGHLIGHTS, 32'(g4));
	endtask

	function automatic bit [23:0] rand_lum();
		return 24'($urandom() >> $urandom_range(0, 31));
	endfunction

	task automatic test_default_regs;
		bit [23:0] pts[10] = '{24'd0, 24'd1, 24'd2, 24'd11796, 24'd47184, 24'd2949,
			24'h01_0000, 24'hFF_FFFF, 24'h80_0000, 24'h7F_FFFF};
		foreach (pts[i]) send_lum(pts[i]);
		drain();
	endtask

	task automatic test_saturation;
		set_all(17'd65536, 12'd2048, 12'd1280, 12'd1280, 12'd1280, 12'd1280, 12'd1280);
		send_lum(24'hFF_FFFF);
		send_lum(24'h10_0000);
		send_lum(24'd0);
		drain();
		set_all(17'd0, 12'd0, 12'h7FF, 12'h800, 12'h7FF, 12'h800, 12'h7FF);
		send_lum(24'd0);
		send_lum(24'd655);
		send_lum(24'hFF_FFFF);
		drain();
	endtask

	task automatic test_far_from_bands;
		set_all(17'd655, 12'd128, 12'h500, 12'hB00, 12'h500, 12'hB00, 12'h500);
		send_lum(24'hFF_FFFF);
		send_lum(24'hF0_0000);
		send_lum(24'd655);
		drain();
		set_all(17'h1FFFF, 12'hFFF, 12'hB00, 12'hB00, 12'hB00, 12'hB00, 12'hB00);
		send_lum(24'd0);
		send_lum(24'hFF_FFFF);
		send_lum(24'd65536);
		drain();
	endtask

	task automatic test_random_stream(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 110 == 0) begin
				drain();
				set_all(17'($urandom()), 12'($urandom()), 12'($urandom_range(0, 4095)),
					12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()));
			end
			send_lum(($urandom_range(0, 3) == 0) ? 24'($urandom()) : rand_lum());
		end
		drain();
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		err_count       = 0;
		send_idle_pct   = 24;
		recv_idle_pct   = 86;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		pix_in.valid   <= 1'b0;
		pix_in.scene_in <= '0;
		grey_reg  = 17'd11796;
		width_reg = 12'd512;
		foreach (band_gain_reg[i]) band_gain_reg[i] = '0;
		exp2_rom[1] = isqrt64(64'h1 << 63);
		for (int k = 2; k <= 16; k++) exp2_rom[k] = isqrt64(exp2_rom[k-1] << 32);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_regs();
		test_saturation();
		test_far_from_bands();
		test_random_stream(660);
		send_idle_pct = 86;
		recv_idle_pct = 24;
		test_random_stream(660);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_stream(660);
		repeat (120) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_tone_equalizer_band_gain_core: clean");
		end else begin
			$display("tb_tone_equalizer_band_gain_core: errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_tone_equalizer_band_gain_core: errors");
		$finish;
	end

endmodule
